### hdl/assert_macros.svh
// shared assertion macros for the frame decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hdl/gbfd_pkg.sv
package gbfd_pkg;

    // sync pattern and frame layout
    localparam logic [7:0]  SYNC0       = 8'hAA;
    localparam logic [7:0]  SYNC1       = 8'h44;
    localparam logic [7:0]  SYNC2       = 8'h12;
    localparam logic [16:0] HDR_LEN     = 17'd28;
    localparam logic [16:0] TRL_LAST    = 17'd3;
    localparam logic [16:0] OFS_ID_LO   = 17'd4;
    localparam logic [16:0] OFS_ID_HI   = 17'd5;
    localparam logic [16:0] OFS_LEN_LO  = 17'd8;
    localparam logic [16:0] OFS_LEN_HI  = 17'd9;
    localparam logic [16:0] OFS_WK_LO   = 17'd14;
    localparam logic [16:0] OFS_WK_HI   = 17'd15;
    localparam logic [16:0] OFS_MS_0    = 17'd16;
    localparam logic [16:0] OFS_MS_1    = 17'd17;
    localparam logic [16:0] OFS_MS_2    = 17'd18;
    localparam logic [16:0] OFS_MS_3    = 17'd19;

    // frame status codes
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // message kind codes
    localparam logic [2:0] KIND_OTHER   = 3'd0;
    localparam logic [2:0] KIND_OBS     = 3'd1;
    localparam logic [2:0] KIND_GPS_EPH = 3'd2;
    localparam logic [2:0] KIND_POS     = 3'd3;
    localparam logic [2:0] KIND_BDS_EPH = 3'd4;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  CFG_MAX_BODY_LEN = 3'd0;
    localparam logic [2:0]  CFG_CRC_POLY     = 3'd1;
    localparam logic [2:0]  CFG_OBS_ID       = 3'd2;
    localparam logic [2:0]  CFG_GPS_EPH_ID   = 3'd3;
    localparam logic [2:0]  CFG_POS_ID       = 3'd4;
    localparam logic [2:0]  CFG_BDS_EPH_ID   = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_MAX_BODY_LEN = 16'd16384;
    localparam logic [31:0] RST_CRC_POLY     = 32'hEDB88320;
    localparam logic [15:0] RST_OBS_ID       = 16'd43;
    localparam logic [15:0] RST_GPS_EPH_ID   = 16'd7;
    localparam logic [15:0] RST_POS_ID       = 16'd42;
    localparam logic [15:0] RST_BDS_EPH_ID   = 16'd1696;

    typedef struct packed {
        logic [15:0] max_body_len;
        logic [31:0] crc_poly;
        logic [15:0] obs_msg_id;
        logic [15:0] gps_eph_msg_id;
        logic [15:0] pos_msg_id;
        logic [15:0] bds_eph_msg_id;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  frame_status;
        logic [2:0]  msg_kind;
        logic [15:0] msg_id;
        logic [15:0] gps_week;
        logic [31:0] week_ms;
        logic [15:0] body_len;
    } result_t;

    // one byte of reflected crc, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

### hdl/gnss_binary_frame_decoder_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// input     | in_valid / in_stall        | byte_in
// result    | out_valid / out_stall      | frame_status msg_kind msg_id gps_week
//           |                            | week_ms body_len
// config    | cfg_valid / cfg_ready      | cfg_index cfg_data
//
// one byte per cycle while in_stall is low; each byte's parse and byte-wide crc step are combinational
// a result appears in the output register the cycle after its last byte is taken
// in_stall rises only while a held result is stalled; cfg_ready is always high
// rst_n clears parse state, result slot and configuration to default values

module gnss_binary_frame_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    byte_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    frame_status,
    output logic [2:0]                    msg_kind,
    output logic [15:0]                   msg_id,
    output logic [15:0]                   gps_week,
    output logic [31:0]                   week_ms,
    output logic [15:0]                   body_len,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    gbfd_pkg::cfg_t    cfg;
    gbfd_pkg::result_t res;
    gbfd_pkg::result_t out_res;
    logic              in_accept;

    // configuration registers
    gbfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // frame parser and crc
    gbfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .byte_in   (byte_in),
        .cfg       (cfg),
        .res       (res)
    );

    // result register
    gbfd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_accept (in_accept),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign frame_status = out_res.frame_status;
    assign msg_kind     = out_res.msg_kind;
    assign msg_id       = out_res.msg_id;
    assign gps_week     = out_res.gps_week;
    assign week_ms      = out_res.week_ms;
    assign body_len     = out_res.body_len;

endmodule

### hdl/gbfd_cfg_regs.sv
module gbfd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output gbfd_pkg::cfg_t                cfg
);

    gbfd_pkg::cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register file, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_body_len   <= gbfd_pkg::RST_MAX_BODY_LEN;
            cfg_reg.crc_poly       <= gbfd_pkg::RST_CRC_POLY;
            cfg_reg.obs_msg_id     <= gbfd_pkg::RST_OBS_ID;
            cfg_reg.gps_eph_msg_id <= gbfd_pkg::RST_GPS_EPH_ID;
            cfg_reg.pos_msg_id     <= gbfd_pkg::RST_POS_ID;
            cfg_reg.bds_eph_msg_id <= gbfd_pkg::RST_BDS_EPH_ID;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gbfd_pkg::CFG_MAX_BODY_LEN: cfg_reg.max_body_len   <= cfg_data[15:0];
                gbfd_pkg::CFG_CRC_POLY:     cfg_reg.crc_poly       <= cfg_data;
                gbfd_pkg::CFG_OBS_ID:       cfg_reg.obs_msg_id     <= cfg_data[15:0];
                gbfd_pkg::CFG_GPS_EPH_ID:   cfg_reg.gps_eph_msg_id <= cfg_data[15:0];
                gbfd_pkg::CFG_POS_ID:       cfg_reg.pos_msg_id     <= cfg_data[15:0];
                gbfd_pkg::CFG_BDS_EPH_ID:   cfg_reg.bds_eph_msg_id <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hdl/gbfd_parser.sv
`include "assert_macros.svh"

module gbfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [7:0]        byte_in,
    input  gbfd_pkg::cfg_t    cfg,
    output gbfd_pkg::result_t res
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SEEN_AA = 4'b0010,
        PH_SEEN_44 = 4'b0100,
        PH_FRAME   = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] week_reg, week_next;
    logic [31:0] ms_reg, ms_next;
    logic [31:0] rx_crc_reg, rx_crc_next;

    logic [31:0] crc_step;
    logic [31:0] crc_first;
    logic [16:0] body_end;
    logic [16:0] trl_ofs;
    logic [2:0]  kind;

    // byte-wide crc update, from running value and from zero
    assign crc_step  = gbfd_pkg::crc_byte(crc_reg, byte_in, cfg.crc_poly);
    assign crc_first = gbfd_pkg::crc_byte(32'd0, byte_in, cfg.crc_poly);
    assign body_end  = gbfd_pkg::HDR_LEN + {1'b0, len_reg};
    assign trl_ofs   = count_reg - body_end;

    // message class, first match wins
    always_comb
    begin
        if (id_reg == cfg.obs_msg_id)
            kind = gbfd_pkg::KIND_OBS;
        else if (id_reg == cfg.gps_eph_msg_id)
            kind = gbfd_pkg::KIND_GPS_EPH;
        else if (id_reg == cfg.pos_msg_id)
            kind = gbfd_pkg::KIND_POS;
        else if (id_reg == cfg.bds_eph_msg_id)
            kind = gbfd_pkg::KIND_BDS_EPH;
        else
            kind = gbfd_pkg::KIND_OTHER;
    end

    // next state and result for the byte on the input
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        week_next   = week_reg;
        ms_next     = ms_reg;
        rx_crc_next = rx_crc_reg;

        res              = '0;
        res.frame_status = gbfd_pkg::STATUS_GOOD;
        res.msg_kind     = gbfd_pkg::KIND_OTHER;

        unique case (phase_reg) inside
            PH_SEEN_AA, PH_SEEN_44:
            begin
                if ((phase_reg == PH_SEEN_AA && byte_in == gbfd_pkg::SYNC1) ||
                    (phase_reg == PH_SEEN_44 && byte_in == gbfd_pkg::SYNC2))
                begin
                    crc_next   = crc_step;
                    count_next = count_reg + 17'd1;
                    phase_next = (phase_reg == PH_SEEN_AA) ? PH_SEEN_44 : PH_FRAME;
                end
                else if (byte_in == gbfd_pkg::SYNC0)
                begin
                    phase_next  = PH_SEEN_AA;
                    count_next  = 17'd1;
                    crc_next    = crc_first;
                    id_next     = '0;
                    len_next    = '0;
                    week_next   = '0;
                    ms_next     = '0;
                    rx_crc_next = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            end
            PH_FRAME:
            begin
                count_next = count_reg + 17'd1;
                if (count_reg < body_end)
                begin
                    // header and body bytes
                    crc_next = crc_step;
                    case (count_reg)
                        gbfd_pkg::OFS_ID_LO:  id_next[7:0]    = byte_in;
                        gbfd_pkg::OFS_ID_HI:  id_next[15:8]   = byte_in;
                        gbfd_pkg::OFS_LEN_LO: len_next[7:0]   = byte_in;
                        gbfd_pkg::OFS_LEN_HI: len_next[15:8]  = byte_in;
                        gbfd_pkg::OFS_WK_LO:  week_next[7:0]  = byte_in;
                        gbfd_pkg::OFS_WK_HI:  week_next[15:8] = byte_in;
                        gbfd_pkg::OFS_MS_0:   ms_next[7:0]    = byte_in;
                        gbfd_pkg::OFS_MS_1:   ms_next[15:8]   = byte_in;
                        gbfd_pkg::OFS_MS_2:   ms_next[23:16]  = byte_in;
                        gbfd_pkg::OFS_MS_3:   ms_next[31:24]  = byte_in;
                        default:
                        begin
                        end
                    endcase
                    // oversized body rejected as soon as its length is known
                    if (count_reg == gbfd_pkg::OFS_LEN_HI && len_next > cfg.max_body_len)
                    begin
                        res.valid        = 1'b1;
                        res.frame_status = gbfd_pkg::STATUS_TOO_LONG;
                        res.msg_id       = id_reg;
                        res.body_len     = len_next;
                        phase_next       = PH_HUNT;
                        count_next       = '0;
                    end
                end
                else
                begin
                    // trailer bytes, little endian
                    case (trl_ofs[1:0])
                        2'd0:    rx_crc_next[7:0]   = byte_in;
                        2'd1:    rx_crc_next[15:8]  = byte_in;
                        2'd2:    rx_crc_next[23:16] = byte_in;
                        default: rx_crc_next[31:24] = byte_in;
                    endcase
                    if (trl_ofs >= gbfd_pkg::TRL_LAST)
                    begin
                        res.valid    = 1'b1;
                        res.msg_id   = id_reg;
                        res.gps_week = week_reg;
                        res.week_ms  = ms_reg;
                        res.body_len = len_reg;
                        if (rx_crc_next == crc_reg)
                        begin
                            res.frame_status = gbfd_pkg::STATUS_GOOD;
                            res.msg_kind     = kind;
                        end
                        else
                        begin
                            res.frame_status = gbfd_pkg::STATUS_CRC_BAD;
                        end
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                if (byte_in == gbfd_pkg::SYNC0)
                begin
                    phase_next  = PH_SEEN_AA;
                    count_next  = 17'd1;
                    crc_next    = crc_first;
                    id_next     = '0;
                    len_next    = '0;
                    week_next   = '0;
                    ms_next     = '0;
                    rx_crc_next = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            end
        endcase
    end

    // parse state, advanced once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            crc_reg    <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            week_reg   <= '0;
            ms_reg     <= '0;
            rx_crc_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            week_reg   <= week_next;
            ms_reg     <= ms_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

    // a result always ends the frame
    `ASSERT_HOLD(a_result_rehunts, clk, rst_n, (in_accept && res.valid) |=> (phase_reg == PH_HUNT && count_reg == 17'd0), "frame not closed after result")
    // byte count stays small outside a frame
    `ASSERT_NEVER(a_count_outside, clk, rst_n, (phase_reg != PH_FRAME && count_reg > 17'd2), "byte count grew outside a frame")
    // length rejection only at the high length byte
    `ASSERT_HOLD(a_too_long_ofs, clk, rst_n, (res.valid && res.frame_status == gbfd_pkg::STATUS_TOO_LONG) |-> (count_reg == gbfd_pkg::OFS_LEN_HI), "length rejection at wrong offset")

endmodule

### hdl/gbfd_out_reg.sv
`include "assert_macros.svh"

module gbfd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              in_accept,
    input  gbfd_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_stall,
    output gbfd_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    gbfd_pkg::result_t data_reg;

    // input waits only while a held result is not being taken
    assign in_stall  = valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    // result slot occupancy
    always_comb
    begin
        if (in_accept)
            valid_next = res.valid;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && res.valid)
            data_reg <= res;
    end

    // a produced result lands in the slot
    `ASSERT_HOLD(a_result_loaded, clk, rst_n, (in_accept && res.valid) |=> valid_reg, "result dropped")
    // a taken result without a new one empties the slot
    `ASSERT_HOLD(a_slot_drains, clk, rst_n, (valid_reg && !out_stall && !(in_accept && res.valid)) |=> !valid_reg, "result repeated")

endmodule

### tb/tb_gnss_binary_frame_decoder_unit.sv
`timescale 1ns / 100ps

module tb_gnss_binary_frame_decoder_unit;

    // parse phases of the frame tracker
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT_AA,
        PH_GOT_44,
        PH_FRAME
    } hunt_phase_t;

    // one frame report as the block should deliver it
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [15:0] id;
        logic [15:0] week;
        logic [31:0] ms;
        logic [15:0] len;
    } frame_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [7:0]                     byte_in = 8'd0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     frame_status;
    logic [2:0]                     msg_kind;
    logic [15:0]                    msg_id;
    logic [15:0]                    gps_week;
    logic [31:0]                    week_ms;
    logic [15:0]                    body_len;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gbfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data = 32'd0;

    // register copies as the block should hold them
    logic [15:0] lim_body_len = gbfd_pkg::RST_MAX_BODY_LEN;
    logic [31:0] poly_cfg = gbfd_pkg::RST_CRC_POLY;
    logic [15:0] id_obs = gbfd_pkg::RST_OBS_ID;
    logic [15:0] id_gps_eph = gbfd_pkg::RST_GPS_EPH_ID;
    logic [15:0] id_pos = gbfd_pkg::RST_POS_ID;
    logic [15:0] id_bds_eph = gbfd_pkg::RST_BDS_EPH_ID;

    // frame tracker state
    hunt_phase_t phase = PH_HUNT;
    logic [16:0] byte_cnt = '0;
    logic [31:0] crc_run = '0;
    logic [15:0] cap_id = '0;
    logic [15:0] cap_len = '0;
    logic [15:0] cap_week = '0;
    logic [31:0] cap_ms = '0;
    logic [31:0] cap_rx = '0;

    frame_report_t frame_reports_q[$];
    int unsigned   reports_due = 0;
    int unsigned   bytes_sent = 0;
    int unsigned   mismatches = 0;
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;
    int unsigned   stall_left = 0;

    gnss_binary_frame_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_status (frame_status),
        .msg_kind     (msg_kind),
        .msg_id       (msg_id),
        .gps_week     (gps_week),
        .week_ms      (week_ms),
        .body_len     (body_len),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always #6 clk = ~clk;

    // reflected crc over one byte, lsb first
    function automatic logic [31:0] crc_advance(input logic [31:0] c, input logic [7:0] b,
                                                input logic [31:0] p);
        logic [31:0] r;
        int          k;
        r = c ^ {24'd0, b};
        for (k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
        end
        return r;
    endfunction

    // message class, first matching register wins
    function automatic logic [2:0] kind_of(input logic [15:0] id);
        if (id == id_obs)
            return gbfd_pkg::KIND_OBS;
        if (id == id_gps_eph)
            return gbfd_pkg::KIND_GPS_EPH;
        if (id == id_pos)
            return gbfd_pkg::KIND_POS;
        if (id == id_bds_eph)
            return gbfd_pkg::KIND_BDS_EPH;
        return gbfd_pkg::KIND_OTHER;
    endfunction

    task automatic push_report(input logic [1:0] status, input logic [2:0] kind,
                               input logic [15:0] week, input logic [31:0] ms);
        frame_report_t r;
        r.status = status;
        r.kind   = kind;
        r.id     = cap_id;
        r.week   = week;
        r.ms     = ms;
        r.len    = cap_len;
        frame_reports_q.insert(frame_reports_q.size(), r);
        reports_due++;
    endtask

    task automatic back_to_hunt();
        phase    = PH_HUNT;
        byte_cnt = '0;
    endtask

    // first sync byte of a candidate frame clears all captures
    task automatic open_frame(input logic [7:0] b);
        phase    = PH_GOT_AA;
        byte_cnt = 17'd1;
        crc_run  = crc_advance(32'd0, b, poly_cfg);
        cap_id   = '0;
        cap_len  = '0;
        cap_week = '0;
        cap_ms   = '0;
        cap_rx   = '0;
    endtask

    // advance the frame tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        logic [16:0] n;
        logic [16:0] body_end;
        logic [16:0] k;
        n = byte_cnt;
        case (phase)
            PH_GOT_AA:
            begin
                if (b == gbfd_pkg::SYNC1)
                begin
                    crc_run  = crc_advance(crc_run, b, poly_cfg);
                    byte_cnt = 17'd2;
                    phase    = PH_GOT_44;
                end
                else if (b == gbfd_pkg::SYNC0)
                    open_frame(b);
                else
                    back_to_hunt();
            end
            PH_GOT_44:
            begin
                if (b == gbfd_pkg::SYNC2)
                begin
                    crc_run  = crc_advance(crc_run, b, poly_cfg);
                    byte_cnt = 17'd3;
                    phase    = PH_FRAME;
                end
                else if (b == gbfd_pkg::SYNC0)
                    open_frame(b);
                else
                    back_to_hunt();
            end
            PH_FRAME:
            begin
                body_end = gbfd_pkg::HDR_LEN + {1'b0, cap_len};
                if (n < body_end)
                begin
                    // header or body byte
                    crc_run = crc_advance(crc_run, b, poly_cfg);
                    case (n)
                        gbfd_pkg::OFS_ID_LO:  cap_id[7:0]    = b;
                        gbfd_pkg::OFS_ID_HI:  cap_id[15:8]   = b;
                        gbfd_pkg::OFS_LEN_LO: cap_len[7:0]   = b;
                        gbfd_pkg::OFS_LEN_HI: cap_len[15:8]  = b;
                        gbfd_pkg::OFS_WK_LO:  cap_week[7:0]  = b;
                        gbfd_pkg::OFS_WK_HI:  cap_week[15:8] = b;
                        gbfd_pkg::OFS_MS_0:   cap_ms[7:0]    = b;
                        gbfd_pkg::OFS_MS_1:   cap_ms[15:8]   = b;
                        gbfd_pkg::OFS_MS_2:   cap_ms[23:16]  = b;
                        gbfd_pkg::OFS_MS_3:   cap_ms[31:24]  = b;
                        default: ;
                    endcase
                    byte_cnt = n + 17'd1;
                    if (n == gbfd_pkg::OFS_LEN_HI && cap_len > lim_body_len)
                    begin
                        push_report(gbfd_pkg::STATUS_TOO_LONG, gbfd_pkg::KIND_OTHER,
                                    16'd0, 32'd0);
                        back_to_hunt();
                    end
                end
                else
                begin
                    // trailer byte, little-endian crc
                    k = n - body_end;
                    cap_rx[8*k[1:0] +: 8] = b;
                    byte_cnt = n + 17'd1;
                    if (k >= gbfd_pkg::TRL_LAST)
                    begin
                        if (cap_rx == crc_run)
                            push_report(gbfd_pkg::STATUS_GOOD, kind_of(cap_id), cap_week,
                                        cap_ms);
                        else
                            push_report(gbfd_pkg::STATUS_CRC_BAD, gbfd_pkg::KIND_OTHER,
                                        cap_week, cap_ms);
                        back_to_hunt();
                    end
                end
            end
            default:
            begin
                if (b == gbfd_pkg::SYNC0)
                    open_frame(b);
                else
                    back_to_hunt();
            end
        endcase
    endtask

    // one byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (in_stall);
        track_byte(b);
        bytes_sent++;
    endtask

    // register write, tracker copy follows on the transfer
    task automatic write_reg(input logic [gbfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gbfd_pkg::CFG_MAX_BODY_LEN: lim_body_len = data[15:0];
            gbfd_pkg::CFG_CRC_POLY:     poly_cfg     = data;
            gbfd_pkg::CFG_OBS_ID:       id_obs       = data[15:0];
            gbfd_pkg::CFG_GPS_EPH_ID:   id_gps_eph   = data[15:0];
            gbfd_pkg::CFG_POS_ID:       id_pos       = data[15:0];
            gbfd_pkg::CFG_BDS_EPH_ID:   id_bds_eph   = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // finish any open frame, then wait for the block to go quiet
    task automatic settle_block();
        while (phase != PH_HUNT)
            send_byte(8'h00);
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_reports_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // 16-bit register value with random upper bits that must be dropped
    function automatic logic [31:0] reg16(input logic [15:0] v);
        return {16'($urandom), v};
    endfunction

    task automatic write_all(input logic [15:0] lim, input logic [31:0] poly,
                             input logic [15:0] obs, input logic [15:0] gps,
                             input logic [15:0] pos, input logic [15:0] bds);
        write_reg(gbfd_pkg::CFG_MAX_BODY_LEN, reg16(lim));
        write_reg(gbfd_pkg::CFG_CRC_POLY, poly);
        write_reg(gbfd_pkg::CFG_OBS_ID, reg16(obs));
        write_reg(gbfd_pkg::CFG_GPS_EPH_ID, reg16(gps));
        write_reg(gbfd_pkg::CFG_POS_ID, reg16(pos));
        write_reg(gbfd_pkg::CFG_BDS_EPH_ID, reg16(bds));
    endtask

    // build a frame with the current polynomial; cut > 0 sends only its head
    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input logic [15:0] week, input logic [31:0] ms,
                              input bit corrupt, input int cut);
        logic [7:0]  bytes_q[$];
        logic [31:0] fcs;
        int          i;
        int          total;
        bytes_q = {};
        for (i = 0; i < 28; i++)
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        bytes_q[0]  = gbfd_pkg::SYNC0;
        bytes_q[1]  = gbfd_pkg::SYNC1;
        bytes_q[2]  = gbfd_pkg::SYNC2;
        bytes_q[3]  = 8'd28;
        bytes_q[4]  = id[7:0];
        bytes_q[5]  = id[15:8];
        bytes_q[8]  = len[7:0];
        bytes_q[9]  = len[15:8];
        bytes_q[14] = week[7:0];
        bytes_q[15] = week[15:8];
        for (i = 0; i < 4; i++)
            bytes_q[16+i] = ms[8*i +: 8];
        for (i = 0; i < len && (cut == 0 || bytes_q.size() < cut); i++)
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        fcs = 32'd0;
        foreach (bytes_q[j])
            fcs = crc_advance(fcs, bytes_q[j], poly_cfg);
        if (corrupt)
            fcs ^= 32'd1 << $urandom_range(0, 31);
        for (i = 0; i < 4; i++)
            bytes_q.insert(bytes_q.size(), fcs[8*i +: 8]);
        total = (cut > 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
        for (i = 0; i < total; i++)
            send_byte(bytes_q[i]);
    endtask

    // stray bytes, leaning on sync values while long bodies cannot run away
    task automatic send_noise(input int count);
        logic [7:0] b;
        int         i;
        for (i = 0; i < count; i++)
        begin
            b = 8'($urandom);
            if (lim_body_len <= 16'd1024 && $urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: b = gbfd_pkg::SYNC0;
                    1: b = gbfd_pkg::SYNC1;
                    default: b = gbfd_pkg::SYNC2;
                endcase
            end
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 5))
            0: return id_obs;
            1: return id_gps_eph;
            2: return id_pos;
            3: return id_bds_eph;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_body_len();
        logic [15:0] top;
        top = (lim_body_len < 16'd24) ? lim_body_len : 16'd24;
        if (lim_body_len <= 16'd64 && $urandom_range(0, 3) == 0)
            return lim_body_len;
        return 16'($urandom_range(0, top));
    endfunction

    function automatic logic [15:0] pick_week();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_ms();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed frames, the rest crc-corrupted and oversized frames, noise and broken sequences
    task automatic random_traffic(input int unsigned min_bytes, input int unsigned min_reports,
                                  input bit allow_cut);
        int unsigned b0;
        int unsigned r0;
        int          pick;
        logic [15:0] len;
        b0 = bytes_sent;
        r0 = reports_due;
        while (bytes_sent - b0 < min_bytes || reports_due - r0 < min_reports)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_frame(pick_id(), pick_body_len(), pick_week(), pick_ms(), 1'b1, 0);
            else if (pick < 25 && lim_body_len != 16'hFFFF)
            begin
                len = ($urandom_range(0, 1) == 0)
                      ? lim_body_len + 16'd1
                      : 16'($urandom_range(lim_body_len + 1, 16'hFFFF));
                send_frame(pick_id(), len, pick_week(), pick_ms(), 1'b0,
                           10 + $urandom_range(0, 8));
            end
            else if (pick < 35)
                send_noise($urandom_range(1, 8));
            else if (pick < 45)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_byte(gbfd_pkg::SYNC0);
                        send_byte(gbfd_pkg::SYNC1);
                        send_byte(8'($urandom_range(0, 255)) == gbfd_pkg::SYNC2 ? 8'h13
                                                                                : 8'h5A);
                    end
                    1:
                    begin
                        send_byte(gbfd_pkg::SYNC0);
                        send_frame(pick_id(), pick_body_len(), pick_week(), pick_ms(), 1'b0, 0);
                    end
                    2:
                    begin
                        send_byte(gbfd_pkg::SYNC0);
                        send_byte(gbfd_pkg::SYNC1);
                        send_frame(pick_id(), pick_body_len(), pick_week(), pick_ms(), 1'b0, 0);
                    end
                    default:
                    begin
                        if (allow_cut)
                            send_frame(pick_id(), pick_body_len(), pick_week(), pick_ms(),
                                       1'b0, $urandom_range(3, 31));
                        else
                            send_noise($urandom_range(1, 4));
                    end
                endcase
            end
            else
                send_frame(pick_id(), pick_body_len(), pick_week(), pick_ms(), 1'b0, 0);
        end
    endtask

    // ---------------- directed tests ----------------

    task automatic test_default_kinds();
        send_frame(gbfd_pkg::RST_OBS_ID, 16'd0, 16'h0000, 32'h0000_0000, 1'b0, 0);
        send_frame(gbfd_pkg::RST_GPS_EPH_ID, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 0);
        send_frame(gbfd_pkg::RST_POS_ID, 16'd3, 16'h1234, 32'h89AB_CDEF, 1'b0, 0);
        send_frame(gbfd_pkg::RST_BDS_EPH_ID, 16'd2, 16'h0800, 32'd302_400_000, 1'b0, 0);
        send_frame(16'h0000, 16'd5, pick_week(), pick_ms(), 1'b0, 0);
        send_frame(16'hFFFF, 16'd4, pick_week(), pick_ms(), 1'b0, 0);
    endtask

    task automatic test_crc_mismatch();
        send_frame(gbfd_pkg::RST_POS_ID, 16'd6, pick_week(), pick_ms(), 1'b1, 0);
        send_frame(16'h5555, 16'd0, pick_week(), pick_ms(), 1'b1, 0);
    endtask

    task automatic test_false_sync();
        send_byte(gbfd_pkg::SYNC1);
        send_byte(gbfd_pkg::SYNC2);
        send_byte(gbfd_pkg::SYNC0);
        send_byte(8'h00);
        send_byte(gbfd_pkg::SYNC0);
        send_byte(gbfd_pkg::SYNC1);
        send_byte(8'hFF);
        send_byte(gbfd_pkg::SYNC0);
        send_frame(gbfd_pkg::RST_OBS_ID, 16'd2, pick_week(), pick_ms(), 1'b0, 0);
        send_byte(gbfd_pkg::SYNC0);
        send_byte(gbfd_pkg::SYNC1);
        send_frame(gbfd_pkg::RST_GPS_EPH_ID, 16'd1, pick_week(), pick_ms(), 1'b0, 0);
    endtask

    task automatic test_oversize_limits();
        send_frame(16'h0101, gbfd_pkg::RST_MAX_BODY_LEN + 16'd1, pick_week(), pick_ms(),
                   1'b0, 10);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 14);
        settle_block();
        write_reg(gbfd_pkg::CFG_MAX_BODY_LEN, reg16(16'd5));
        send_frame(gbfd_pkg::RST_OBS_ID, 16'd5, pick_week(), pick_ms(), 1'b0, 0);
        send_frame(gbfd_pkg::RST_OBS_ID, 16'd6, pick_week(), pick_ms(), 1'b0, 12);
        settle_block();
        write_reg(gbfd_pkg::CFG_MAX_BODY_LEN, reg16(16'd0));
        send_frame(gbfd_pkg::RST_POS_ID, 16'd0, pick_week(), pick_ms(), 1'b0, 0);
        send_frame(gbfd_pkg::RST_POS_ID, 16'd1, pick_week(), pick_ms(), 1'b0, 10);
        send_frame(gbfd_pkg::RST_POS_ID, 16'h0100, pick_week(), pick_ms(), 1'b0, 10);
    endtask

    task automatic test_kind_priority();
        settle_block();
        write_all(16'd64, gbfd_pkg::RST_CRC_POLY, 16'd500, 16'd500, 16'd500, 16'd500);
        send_frame(16'd500, 16'd3, pick_week(), pick_ms(), 1'b0, 0);
        settle_block();
        write_reg(gbfd_pkg::CFG_OBS_ID, reg16(16'd1));
        send_frame(16'd500, 16'd0, pick_week(), pick_ms(), 1'b0, 0);
        settle_block();
        write_reg(gbfd_pkg::CFG_GPS_EPH_ID, reg16(16'd2));
        send_frame(16'd500, 16'd0, pick_week(), pick_ms(), 1'b0, 0);
        settle_block();
        write_reg(gbfd_pkg::CFG_POS_ID, reg16(16'd3));
        send_frame(16'd500, 16'd0, pick_week(), pick_ms(), 1'b0, 0);
        send_frame(16'd3, 16'd0, pick_week(), pick_ms(), 1'b0, 0);
    endtask

    // ---------------- random tests ----------------

    task automatic test_random_defaults();
        settle_block();
        write_all(gbfd_pkg::RST_MAX_BODY_LEN, gbfd_pkg::RST_CRC_POLY, gbfd_pkg::RST_OBS_ID,
                  gbfd_pkg::RST_GPS_EPH_ID, gbfd_pkg::RST_POS_ID, gbfd_pkg::RST_BDS_EPH_ID);
        random_traffic(24, 1, 1'b0);
    endtask

    task automatic test_random_zero_limit();
        logic [15:0] dup;
        settle_block();
        dup = 16'($urandom);
        write_all(16'd0, $urandom, dup, dup, 16'($urandom), 16'($urandom));
        random_traffic(24, 1, 1'b1);
    endtask

    task automatic test_random_full_limit();
        settle_block();
        write_all(16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'($urandom));
        random_traffic(24, 1, 1'b0);
    endtask

    task automatic test_random_small_limit();
        settle_block();
        write_all(16'($urandom_range(16, 48)), 32'h0000_0000, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        random_traffic(24, 1, 1'b1);
    endtask

    task automatic test_random_no_idle();
        settle_block();
        write_all(16'($urandom_range(1, 1024)), gbfd_pkg::RST_CRC_POLY, gbfd_pkg::RST_OBS_ID,
                  gbfd_pkg::RST_GPS_EPH_ID, gbfd_pkg::RST_POS_ID, gbfd_pkg::RST_BDS_EPH_ID);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_traffic(24, 1, 1'b1);
    endtask

    // result stall bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    // compare each result transfer with the oldest expected report
    always @(posedge clk)
    begin
        frame_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_reports_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result status %0d kind %0d id %h len %h",
                             $realtime, frame_status, msg_kind, msg_id, body_len);
            end
            else
            begin
                want = frame_reports_q.pop_front();
                if (frame_status !== want.status || msg_kind !== want.kind ||
                    msg_id !== want.id || gps_week !== want.week ||
                    week_ms !== want.ms || body_len !== want.len)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: expected status %0d kind %0d id %h week %h ms %h len %h",
                                 $realtime, want.status, want.kind, want.id, want.week,
                                 want.ms, want.len);
                        $display("%0t: actual   status %0d kind %0d id %h week %h ms %h len %h",
                                 $realtime, frame_status, msg_kind, msg_id, gps_week,
                                 week_ms, body_len);
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_kinds();
        test_crc_mismatch();
        test_false_sync();
        test_oversize_limits();
        test_kind_priority();
        test_random_defaults();
        test_random_zero_limit();
        test_random_full_limit();
        test_random_small_limit();
        test_random_no_idle();
        settle_block();
        if (mismatches == 0 && frame_reports_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/gbfd_pkg.sv
hdl/gbfd_cfg_regs.sv
hdl/gbfd_parser.sv
hdl/gbfd_out_reg.sv
hdl/gnss_binary_frame_decoder_unit.sv
tb/tb_gnss_binary_frame_decoder_unit.sv
